@@ rtl/core/nhm_pkg.sv @@
// shared types and codes of the node heartbeat health monitor
package nhm_pkg;

  localparam int ACTION_W = 3;
  localparam int NODE_W   = 4;
  localparam int ROLE_W   = 3;
  localparam int LOAD_W   = 32;
  localparam int TIME_W   = 48;
  localparam int INTV_W   = 40;
  localparam int MISS_W   = 16;
  localparam int THR_W    = 8;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 2;
  localparam int DEADT_W  = 5;
  localparam int CFGI_W   = 2;

  localparam logic [ACTION_W-1:0] ACT_REG   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_HB    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_UNREG = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FIND  = 3'd4;

  localparam logic [KIND_W-1:0] KIND_ACK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ERR    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DIED   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TDONE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CAND   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NOCAND = 3'd5;

  localparam logic [STAT_W-1:0] ST_HEALTHY = 2'd0;
  localparam logic [STAT_W-1:0] ST_SUSPECT = 2'd1;
  localparam logic [STAT_W-1:0] ST_DEAD    = 2'd2;

  localparam logic [CFGI_W-1:0] CFG_INTERVAL = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_SUSPECT  = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_DEAD     = 2'd2;

  localparam logic [MISS_W-1:0] MISS_SAT = 16'hFFFF;

  typedef struct packed {
    logic [ROLE_W-1:0] role;
    logic [STAT_W-1:0] status;
    logic [TIME_W-1:0] last_seen;
    logic [LOAD_W-1:0] load;
    logic [MISS_W-1:0] missed;
  } slot_word_t;

endpackage

@@ rtl/core/nhm_ram.sv @@
// generic single write port ram with registered read
module nhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/nhm_div.sv @@
// restoring divider for missed windows, quotient saturates at 16 bits
module nhm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [nhm_pkg::TIME_W-1:0]  dividend,
  input  logic [nhm_pkg::INTV_W-1:0]  divisor,
  output logic                        done,
  output logic [nhm_pkg::MISS_W-1:0]  quotient
);
  import nhm_pkg::*;

  localparam int SH_W = INTV_W + MISS_W;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [SH_W-1:0]   dsh_r, dsh_nxt;
  logic [MISS_W-1:0] q_r, q_nxt;
  logic              sat, fits;

  assign sat  = {{(SH_W-TIME_W){1'b0}}, dividend} >= {divisor, {MISS_W{1'b0}}};
  assign fits = {{(SH_W-TIME_W){1'b0}}, rem_r} >= dsh_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    if (start) begin
      if (sat) begin
        q_nxt    = MISS_SAT;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = dividend;
        dsh_nxt  = {1'b0, divisor, {(MISS_W-1){1'b0}}};
        cnt_nxt  = 4'd15;
        q_nxt    = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_r[TIME_W-1:0];
      end
      q_nxt   = {q_r[MISS_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

@@ rtl/core/node_heartbeat_health_monitor.sv @@
// top level of the node heartbeat health monitor: sequencer around the slot table
//
// input channel (in_*): one command per transfer, taken when in_valid is high
// and in_stall is low; in_stall is high whenever a command is still being
// worked on. result channel (out_*): results leave through an output register,
// out_last marks the final result of a command; a result is held while
// out_stall is high, and the sequencer waits for the register to free up.
// configuration (cfg_*): cfg_ready is always high, writes are meant for idle.
// register, heartbeat and unregister read their slot, then act on it and
// emit their result. a tick (unless the interval is zero) walks all slots,
// running the shared bit-serial divider for each live slot, then makes a
// report pass over the slots. find makes one scan over all slots per
// candidate plus one. the slot table sits in one ram with one read and one
// write port. reset clears presence, dead count and registers to their
// defaults; no clearing pass is needed.
module node_heartbeat_health_monitor #(
  parameter int NODES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [nhm_pkg::ACTION_W-1:0] in_action,
  input  logic [nhm_pkg::NODE_W-1:0]   in_node,
  input  logic [nhm_pkg::ROLE_W-1:0]   in_role,
  input  logic [nhm_pkg::LOAD_W-1:0]   in_load,
  input  logic [nhm_pkg::TIME_W-1:0]   in_now,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nhm_pkg::KIND_W-1:0]   out_kind,
  output logic [nhm_pkg::NODE_W-1:0]   out_node_out,
  output logic [nhm_pkg::ROLE_W-1:0]   out_role_out,
  output logic [nhm_pkg::STAT_W-1:0]   out_status,
  output logic [nhm_pkg::LOAD_W-1:0]   out_load_out,
  output logic [nhm_pkg::DEADT_W-1:0]  out_dead_total,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [nhm_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [nhm_pkg::INTV_W-1:0]   cfg_data
);
  import nhm_pkg::*;

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int DW = $clog2(NODES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);
  localparam int WW = $bits(slot_word_t);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_N_WAIT = 4'd1;
  localparam logic [3:0] S_N_EXEC = 4'd2;
  localparam logic [3:0] S_T_WAIT = 4'd3;
  localparam logic [3:0] S_T_CHK  = 4'd4;
  localparam logic [3:0] S_T_DIV  = 4'd5;
  localparam logic [3:0] S_D_WAIT = 4'd6;
  localparam logic [3:0] S_D_CHK  = 4'd7;
  localparam logic [3:0] S_T_DONE = 4'd8;
  localparam logic [3:0] S_F_WAIT = 4'd9;
  localparam logic [3:0] S_F_CHK  = 4'd10;
  localparam logic [3:0] S_F_END  = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;

  // control state
  logic [3:0]       state_r, state_nxt;
  logic [3:0]       ret_r, ret_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [NODES-1:0] present_r, present_nxt;
  logic [NODES-1:0] died_r, died_nxt;
  logic [DW-1:0]    dead_cnt_r, dead_cnt_nxt;
  logic             prev_v_r, prev_v_nxt;
  logic             best_v_r, best_v_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [INTV_W-1:0] interval_r;
  logic [THR_W-1:0]  suspect_r;
  logic [THR_W-1:0]  deadthr_r;

  // latched command
  logic [ACTION_W-1:0] act_r;
  logic [ROLE_W-1:0]   role_r;
  logic [LOAD_W-1:0]   load_r;
  logic [TIME_W-1:0]   now_r;

  // find pass tracking
  logic [LOAD_W-1:0] prev_load_r, prev_load_nxt;
  logic [IW-1:0]     prev_id_r, prev_id_nxt;
  logic [STAT_W-1:0] prev_st_r, prev_st_nxt;
  logic [LOAD_W-1:0] best_load_r, best_load_nxt;
  logic [IW-1:0]     best_id_r, best_id_nxt;
  logic [STAT_W-1:0] best_st_r, best_st_nxt;

  // pending result
  logic [KIND_W-1:0] res_kind_r, res_kind_nxt;
  logic [NODE_W-1:0] res_node_r, res_node_nxt;
  logic [ROLE_W-1:0] res_role_r, res_role_nxt;
  logic [STAT_W-1:0] res_st_r, res_st_nxt;
  logic [LOAD_W-1:0] res_load_r, res_load_nxt;
  logic              res_last_r, res_last_nxt;

  // output register
  logic [KIND_W-1:0]  o_kind_r;
  logic [NODE_W-1:0]  o_node_r;
  logic [ROLE_W-1:0]  o_role_r;
  logic [STAT_W-1:0]  o_st_r;
  logic [LOAD_W-1:0]  o_load_r;
  logic [DEADT_W-1:0] o_dead_r;
  logic               o_last_r;
  logic               out_load_en;

  // slot table and divider
  logic          ram_we;
  slot_word_t    ram_wdata;
  logic [WW-1:0] ram_rdata;
  slot_word_t    rd_word;
  logic          div_start;
  logic          div_done;
  logic [MISS_W-1:0] div_q;

  logic in_acc;
  logic cfg_acc;
  logic pres;
  logic was_dead;
  logic elig;
  logic at_last;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign rd_word   = slot_word_t'(ram_rdata);
  assign pres      = present_r[idx_r];
  assign was_dead  = pres && (rd_word.status == ST_DEAD);
  assign at_last   = (idx_r == LAST_IDX);

  // candidate order is (load, id) strictly after the previous pick
  assign elig = pres && (rd_word.status != ST_DEAD) && (rd_word.role == role_r) &&
                (!prev_v_r || (rd_word.load > prev_load_r) ||
                 ((rd_word.load == prev_load_r) && (idx_r > prev_id_r)));

  nhm_ram #(
    .WIDTH (WW),
    .DEPTH (NODES)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  nhm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (now_r - rd_word.last_seen),
    .divisor  (interval_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    idx_nxt       = idx_r;
    present_nxt   = present_r;
    died_nxt      = died_r;
    dead_cnt_nxt  = dead_cnt_r;
    prev_v_nxt    = prev_v_r;
    best_v_nxt    = best_v_r;
    prev_load_nxt = prev_load_r;
    prev_id_nxt   = prev_id_r;
    prev_st_nxt   = prev_st_r;
    best_load_nxt = best_load_r;
    best_id_nxt   = best_id_r;
    best_st_nxt   = best_st_r;
    res_kind_nxt  = res_kind_r;
    res_node_nxt  = res_node_r;
    res_role_nxt  = res_role_r;
    res_st_nxt    = res_st_r;
    res_load_nxt  = res_load_r;
    res_last_nxt  = res_last_r;
    ram_we        = 1'b0;
    ram_wdata     = rd_word;
    div_start     = 1'b0;
    out_load_en   = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt      = IW'(in_node);
          res_load_nxt = '0;
          res_last_nxt = 1'b1;
          ret_nxt      = S_IDLE;
          if ((in_action == ACT_REG || in_action == ACT_HB || in_action == ACT_UNREG) &&
              (32'(in_node) >= NODES)) begin
            // slot outside the table
            res_kind_nxt = KIND_ERR;
            res_node_nxt = in_node;
            res_role_nxt = '0;
            res_st_nxt   = ST_DEAD;
            state_nxt    = S_EMIT;
          end else begin
            case (in_action)
              ACT_REG, ACT_HB, ACT_UNREG: begin
                state_nxt = S_N_WAIT;
              end
              ACT_TICK: begin
                idx_nxt  = '0;
                died_nxt = '0;
                if (interval_r == '0) begin
                  state_nxt = S_T_DONE;
                end else begin
                  state_nxt = S_T_WAIT;
                end
              end
              ACT_FIND: begin
                idx_nxt    = '0;
                prev_v_nxt = 1'b0;
                best_v_nxt = 1'b0;
                state_nxt  = S_F_WAIT;
              end
              default: begin
                res_kind_nxt = KIND_ERR;
                res_node_nxt = in_node;
                res_role_nxt = '0;
                res_st_nxt   = ST_DEAD;
                state_nxt    = S_EMIT;
              end
            endcase
          end
        end
      end

      S_N_WAIT: begin
        state_nxt = S_N_EXEC;
      end

      S_N_EXEC: begin
        res_node_nxt = 4'(idx_r);
        state_nxt    = S_EMIT;
        case (act_r)
          ACT_REG: begin
            ram_we           = 1'b1;
            ram_wdata.role   = role_r;
            ram_wdata.status = ST_HEALTHY;
            ram_wdata.last_seen = now_r;
            ram_wdata.load   = load_r;
            ram_wdata.missed = '0;
            present_nxt[idx_r] = 1'b1;
            if (was_dead) begin
              dead_cnt_nxt = dead_cnt_r - DW'(1);
            end
            res_kind_nxt = KIND_ACK;
            res_role_nxt = role_r;
            res_st_nxt   = ST_HEALTHY;
          end
          ACT_HB: begin
            if (!pres) begin
              res_kind_nxt = KIND_ERR;
              res_role_nxt = '0;
              res_st_nxt   = ST_DEAD;
            end else if (was_dead) begin
              res_kind_nxt = KIND_ERR;
              res_role_nxt = rd_word.role;
              res_st_nxt   = ST_DEAD;
            end else begin
              ram_we           = 1'b1;
              ram_wdata.status = ST_HEALTHY;
              ram_wdata.last_seen = now_r;
              ram_wdata.load   = load_r;
              ram_wdata.missed = '0;
              res_kind_nxt = KIND_ACK;
              res_role_nxt = rd_word.role;
              res_st_nxt   = ST_HEALTHY;
            end
          end
          default: begin
            // unregister
            present_nxt[idx_r] = 1'b0;
            if (was_dead) begin
              dead_cnt_nxt = dead_cnt_r - DW'(1);
            end
            res_kind_nxt = KIND_ACK;
            res_role_nxt = '0;
            res_st_nxt   = ST_DEAD;
          end
        endcase
      end

      S_T_WAIT: begin
        state_nxt = S_T_CHK;
      end

      S_T_CHK: begin
        if (pres && rd_word.status != ST_DEAD && now_r >= rd_word.last_seen) begin
          div_start = 1'b1;
          state_nxt = S_T_DIV;
        end else if (at_last) begin
          idx_nxt   = '0;
          state_nxt = S_D_WAIT;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_T_WAIT;
        end
      end

      S_T_DIV: begin
        if (div_done) begin
          if (div_q != rd_word.missed) begin
            ram_we           = 1'b1;
            ram_wdata.missed = div_q;
            if (div_q >= MISS_W'(deadthr_r)) begin
              ram_wdata.status = ST_DEAD;
              died_nxt[idx_r]  = 1'b1;
              dead_cnt_nxt     = dead_cnt_r + DW'(1);
            end else if (div_q >= MISS_W'(suspect_r)) begin
              ram_wdata.status = ST_SUSPECT;
            end
          end
          if (at_last) begin
            idx_nxt   = '0;
            state_nxt = S_D_WAIT;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_T_WAIT;
          end
        end
      end

      // report pass over the slots that died in this tick
      S_D_WAIT: begin
        state_nxt = S_D_CHK;
      end

      S_D_CHK: begin
        if (at_last) begin
          ret_nxt = S_T_DONE;
        end else begin
          idx_nxt = idx_r + IW'(1);
          ret_nxt = S_D_WAIT;
        end
        if (died_r[idx_r]) begin
          res_kind_nxt = KIND_DIED;
          res_node_nxt = 4'(idx_r);
          res_role_nxt = rd_word.role;
          res_st_nxt   = ST_DEAD;
          res_load_nxt = '0;
          res_last_nxt = 1'b0;
          state_nxt    = S_EMIT;
        end else if (at_last) begin
          state_nxt = S_T_DONE;
        end else begin
          state_nxt = S_D_WAIT;
        end
      end

      S_T_DONE: begin
        res_kind_nxt = KIND_TDONE;
        res_node_nxt = '0;
        res_role_nxt = '0;
        res_st_nxt   = ST_HEALTHY;
        res_load_nxt = '0;
        res_last_nxt = 1'b1;
        ret_nxt      = S_IDLE;
        state_nxt    = S_EMIT;
      end

      S_F_WAIT: begin
        state_nxt = S_F_CHK;
      end

      S_F_CHK: begin
        if (elig && (!best_v_r || rd_word.load < best_load_r)) begin
          best_v_nxt    = 1'b1;
          best_load_nxt = rd_word.load;
          best_id_nxt   = idx_r;
          best_st_nxt   = rd_word.status;
        end
        if (at_last) begin
          state_nxt = S_F_END;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_F_WAIT;
        end
      end

      // one candidate is held back so that the final one can carry last
      S_F_END: begin
        idx_nxt      = '0;
        best_v_nxt   = 1'b0;
        res_kind_nxt = KIND_CAND;
        res_node_nxt = 4'(prev_id_r);
        res_role_nxt = role_r;
        res_st_nxt   = prev_st_r;
        res_load_nxt = prev_load_r;
        if (best_v_r) begin
          prev_v_nxt    = 1'b1;
          prev_load_nxt = best_load_r;
          prev_id_nxt   = best_id_r;
          prev_st_nxt   = best_st_r;
          res_last_nxt  = 1'b0;
          ret_nxt       = S_F_WAIT;
          state_nxt     = prev_v_r ? S_EMIT : S_F_WAIT;
        end else begin
          res_last_nxt = 1'b1;
          ret_nxt      = S_IDLE;
          state_nxt    = S_EMIT;
          if (!prev_v_r) begin
            res_kind_nxt = KIND_NOCAND;
            res_node_nxt = '0;
            res_role_nxt = '0;
            res_st_nxt   = ST_DEAD;
            res_load_nxt = '0;
          end
        end
      end

      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load_en   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ret_r;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      present_r   <= '0;
      died_r      <= '0;
      dead_cnt_r  <= '0;
      prev_v_r    <= 1'b0;
      best_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      interval_r  <= INTV_W'(1000);
      suspect_r   <= THR_W'(3);
      deadthr_r   <= THR_W'(5);
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      present_r   <= present_nxt;
      died_r      <= died_nxt;
      dead_cnt_r  <= dead_cnt_nxt;
      prev_v_r    <= prev_v_nxt;
      best_v_r    <= best_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_acc) begin
        case (cfg_index)
          CFG_INTERVAL: interval_r <= cfg_data;
          CFG_SUSPECT:  suspect_r  <= cfg_data[THR_W-1:0];
          CFG_DEAD:     deadthr_r  <= cfg_data[THR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    prev_load_r <= prev_load_nxt;
    prev_id_r   <= prev_id_nxt;
    prev_st_r   <= prev_st_nxt;
    best_load_r <= best_load_nxt;
    best_id_r   <= best_id_nxt;
    best_st_r   <= best_st_nxt;
    res_kind_r  <= res_kind_nxt;
    res_node_r  <= res_node_nxt;
    res_role_r  <= res_role_nxt;
    res_st_r    <= res_st_nxt;
    res_load_r  <= res_load_nxt;
    res_last_r  <= res_last_nxt;
    if (in_acc) begin
      act_r  <= in_action;
      role_r <= in_role;
      load_r <= in_load;
      now_r  <= in_now;
    end
    if (out_load_en) begin
      o_kind_r <= res_kind_r;
      o_node_r <= res_node_r;
      o_role_r <= res_role_r;
      o_st_r   <= res_st_r;
      o_load_r <= res_load_r;
      o_dead_r <= DEADT_W'(dead_cnt_r);
      o_last_r <= res_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = o_kind_r;
  assign out_node_out   = o_node_r;
  assign out_role_out   = o_role_r;
  assign out_status     = o_st_r;
  assign out_load_out   = o_load_r;
  assign out_dead_total = o_dead_r;
  assign out_last       = o_last_r;
endmodule
